[sv/xxh64_pkg.sv]
// xxh64_pkg: constants, types and helper functions for the streaming XXH64 block.
// Used by every module of the block; has no dependencies.
package xxh64_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  localparam int LENGTH_BITS_DEF = 64;
  localparam int FIFO_DEPTH = 2;

  // One classified word from front to back.
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        first;
    logic [63:0] seed;
  } fe_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_RND_MUL,
    S_RND_ROT,
    S_RND_MUL2,
    S_FIN_ROT,
    S_FIN_MRG_MUL,
    S_FIN_MRG_ROT,
    S_FIN_MRG_MUL2,
    S_FIN_MRG_MUL3,
    S_FIN_LEN,
    S_T8_MUL,
    S_T8_ROT,
    S_T8_MUL2,
    S_T8_MUL3,
    S_T4_MUL,
    S_T4_MUL2,
    S_T1_MUL,
    S_T1_MUL2,
    S_AV1,
    S_AV2,
    S_AV3,
    S_AV4,
    S_OUT
  } be_state_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
    rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

endpackage

[sv/xxh64_front.sv]
// xxh64_front: accepts input items, normalizes byte counts and masks, marks message start.
// Depends on xxh64_pkg.
module xxh64_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          seed,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [63:0]          in_word,
  input  logic [3:0]           in_count,
  input  logic                 in_last,
  output logic                 push,
  output xxh64_pkg::fe_item_t  push_item,
  input  logic                 full
);

  logic in_msg;
  logic [3:0] nb;
  logic [63:0] mask;

  assign in_ready = !full;
  assign push = in_valid && in_ready;

  always_comb begin
    nb = in_last ? ((in_count > 4'd8) ? 4'd8 : in_count) : 4'd8;
    mask = (nb == 4'd8) ? '1 : ~({64{1'b1}} << {nb[2:0], 3'b000});
    push_item.word = in_word & mask;
    push_item.nbytes = nb;
    push_item.last = in_last;
    push_item.first = !in_msg;
    push_item.seed = seed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_msg <= 1'b0;
    end else if (push) begin
      in_msg <= !in_last;
    end
  end

endmodule

[sv/xxh64_fifo.sv]
// xxh64_fifo: short item queue between front and back.
// Depends on xxh64_pkg.
module xxh64_fifo #(
  parameter int DEPTH = xxh64_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  xxh64_pkg::fe_item_t push_item,
  output logic                full,
  input  logic                pop,
  output xxh64_pkg::fe_item_t pop_item,
  output logic                empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  xxh64_pkg::fe_item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign pop_item = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

[sv/xxh64_back.sv]
// xxh64_back: lane rounds, merge, tail folding and avalanche on a shared multiplier.
// Depends on xxh64_pkg.
module xxh64_back #(
  parameter int LENGTH_BITS = xxh64_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  xxh64_pkg::fe_item_t item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_hash
);

  xxh64_pkg::be_state_t state, state_next;

  logic [63:0] lane [4];
  logic [63:0] pend [3];
  logic [1:0]  pcnt;
  logic [LENGTH_BITS-1:0] total;
  logic [63:0] mseed;
  logic [63:0] word;
  logic [3:0]  nb;
  logic        lst;
  logic [1:0]  li;
  logic [1:0]  ti;
  logic [63:0] h;
  logic [63:0] t;
  logic [63:0] hv;
  logic        hv_valid;
  logic [LENGTH_BITS-1:0] total_add;
  logic [63:0] mul_a, mul_b;
  logic [63:0] acc;
  logic [63:0] mprod;
  logic [31:0] m_x, m_y;
  logic [1:0]  mph;
  logic        mul_st;
  logic        step;

  assign out_hash = hv;
  assign out_valid = hv_valid;
  assign total_add = total + LENGTH_BITS'(item.nbytes);

  // 64x64 low product on one 32x32 multiplier: lo*lo, lo*hi, hi*lo, then result in acc
  assign m_x = mph[1] ? mul_a[63:32] : mul_a[31:0];
  assign m_y = (mph == 2'd1) ? mul_b[63:32] : mul_b[31:0];
  assign mprod = 64'(m_x) * 64'(m_y);
  assign step = !mul_st || (mph == 2'd3);

  always_comb begin
    mul_st = 1'b1;
    mul_a = h;
    mul_b = xxh64_pkg::P1;
    case (state)
      xxh64_pkg::S_RND_MUL: begin
        mul_a = (li == 2'd3) ? word : pend[li];
        mul_b = xxh64_pkg::P2;
      end
      xxh64_pkg::S_RND_MUL2, xxh64_pkg::S_FIN_MRG_MUL2, xxh64_pkg::S_T8_MUL2: mul_a = t;
      xxh64_pkg::S_FIN_MRG_MUL: begin
        mul_a = lane[li];
        mul_b = xxh64_pkg::P2;
      end
      xxh64_pkg::S_FIN_MRG_MUL3, xxh64_pkg::S_T8_MUL3, xxh64_pkg::S_T1_MUL2: ;
      xxh64_pkg::S_T8_MUL: begin
        mul_a = (ti != pcnt) ? pend[ti] : word;
        mul_b = xxh64_pkg::P2;
      end
      xxh64_pkg::S_T4_MUL:  mul_a = {32'd0, word[31:0]};
      xxh64_pkg::S_T4_MUL2: mul_b = xxh64_pkg::P2;
      xxh64_pkg::S_T1_MUL: begin
        mul_a = {56'd0, word[7:0]};
        mul_b = xxh64_pkg::P5;
      end
      xxh64_pkg::S_AV1: begin
        mul_a = h ^ (h >> 33);
        mul_b = xxh64_pkg::P2;
      end
      xxh64_pkg::S_AV3: mul_b = xxh64_pkg::P3;
      default: mul_st = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xxh64_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    case (state)
      xxh64_pkg::S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          state_next = xxh64_pkg::S_LOAD;
        end
      end
      xxh64_pkg::S_LOAD: begin
        if (!lst) begin
          state_next = (pcnt == 2'd3) ? xxh64_pkg::S_RND_MUL : xxh64_pkg::S_IDLE;
        end else if (nb == 4'd8 && pcnt == 2'd3) begin
          state_next = xxh64_pkg::S_RND_MUL;
        end else begin
          state_next = xxh64_pkg::S_FIN_ROT;
        end
      end
      xxh64_pkg::S_RND_MUL:  state_next = xxh64_pkg::S_RND_ROT;
      xxh64_pkg::S_RND_ROT:  state_next = xxh64_pkg::S_RND_MUL2;
      xxh64_pkg::S_RND_MUL2: begin
        if (li != 2'd3) begin
          state_next = xxh64_pkg::S_RND_MUL;
        end else begin
          state_next = lst ? xxh64_pkg::S_FIN_ROT : xxh64_pkg::S_IDLE;
        end
      end
      xxh64_pkg::S_FIN_ROT: begin
        state_next = (total >= LENGTH_BITS'(32)) ? xxh64_pkg::S_FIN_MRG_MUL
                                                : xxh64_pkg::S_FIN_LEN;
      end
      xxh64_pkg::S_FIN_MRG_MUL:  state_next = xxh64_pkg::S_FIN_MRG_ROT;
      xxh64_pkg::S_FIN_MRG_ROT:  state_next = xxh64_pkg::S_FIN_MRG_MUL2;
      xxh64_pkg::S_FIN_MRG_MUL2: state_next = xxh64_pkg::S_FIN_MRG_MUL3;
      xxh64_pkg::S_FIN_MRG_MUL3: begin
        state_next = (li == 2'd3) ? xxh64_pkg::S_FIN_LEN : xxh64_pkg::S_FIN_MRG_MUL;
      end
      xxh64_pkg::S_FIN_LEN: begin
        if (pcnt != 2'd0) begin
          state_next = xxh64_pkg::S_T8_MUL;
        end else if (nb == 4'd8) begin
          state_next = xxh64_pkg::S_T8_MUL;
        end else if (nb >= 4'd4) begin
          state_next = xxh64_pkg::S_T4_MUL;
        end else if (nb != 4'd0) begin
          state_next = xxh64_pkg::S_T1_MUL;
        end else begin
          state_next = xxh64_pkg::S_AV1;
        end
      end
      xxh64_pkg::S_T8_MUL:  state_next = xxh64_pkg::S_T8_ROT;
      xxh64_pkg::S_T8_ROT:  state_next = xxh64_pkg::S_T8_MUL2;
      xxh64_pkg::S_T8_MUL2: state_next = xxh64_pkg::S_T8_MUL3;
      xxh64_pkg::S_T8_MUL3: begin
        if (ti == pcnt) begin
          state_next = xxh64_pkg::S_AV1;
        end else if ((ti + 2'd1) != pcnt) begin
          state_next = xxh64_pkg::S_T8_MUL;
        end else if (nb == 4'd8) begin
          state_next = xxh64_pkg::S_T8_MUL;
        end else if (nb >= 4'd4) begin
          state_next = xxh64_pkg::S_T4_MUL;
        end else if (nb != 4'd0) begin
          state_next = xxh64_pkg::S_T1_MUL;
        end else begin
          state_next = xxh64_pkg::S_AV1;
        end
      end
      xxh64_pkg::S_T4_MUL:  state_next = xxh64_pkg::S_T4_MUL2;
      xxh64_pkg::S_T4_MUL2: begin
        state_next = (nb != 4'd0) ? xxh64_pkg::S_T1_MUL : xxh64_pkg::S_AV1;
      end
      xxh64_pkg::S_T1_MUL:  state_next = xxh64_pkg::S_T1_MUL2;
      xxh64_pkg::S_T1_MUL2: begin
        state_next = (nb != 4'd0) ? xxh64_pkg::S_T1_MUL : xxh64_pkg::S_AV1;
      end
      xxh64_pkg::S_AV1: state_next = xxh64_pkg::S_AV2;
      xxh64_pkg::S_AV2: state_next = xxh64_pkg::S_AV3;
      xxh64_pkg::S_AV3: state_next = xxh64_pkg::S_AV4;
      xxh64_pkg::S_AV4: state_next = xxh64_pkg::S_OUT;
      xxh64_pkg::S_OUT: begin
        if (!hv_valid || out_ready) begin
          state_next = xxh64_pkg::S_IDLE;
        end
      end
      default: state_next = xxh64_pkg::S_IDLE;
    endcase
    if (!step) begin
      state_next = state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= '0;
      total <= '0;
      hv_valid <= 1'b0;
      mph <= '0;
    end else begin
      if (hv_valid && out_ready && state != xxh64_pkg::S_OUT) begin
        hv_valid <= 1'b0;
      end
      if (!step) begin
        mph <= mph + 2'd1;
        acc <= (mph == 2'd0) ? mprod : acc + {mprod[31:0], 32'd0};
      end else begin
        mph <= '0;
        case (state)
          xxh64_pkg::S_IDLE: begin
            if (!empty) begin
              word <= item.word;
              nb <= item.nbytes;
              lst <= item.last;
              li <= '0;
              ti <= '0;
              if (item.first) begin
                mseed <= item.seed;
                lane[0] <= item.seed + xxh64_pkg::P1 + xxh64_pkg::P2;
                lane[1] <= item.seed + xxh64_pkg::P2;
                lane[2] <= item.seed;
                lane[3] <= item.seed - xxh64_pkg::P1;
                pcnt <= '0;
                total <= item.first ? LENGTH_BITS'(item.nbytes)
                                    : total_add;
              end else begin
                total <= total_add;
              end
            end
          end
          xxh64_pkg::S_LOAD: begin
            if (pcnt == 2'd3 && nb == 4'd8) begin
              pcnt <= '0;
              nb <= '0;
            end else if (!lst) begin
              pend[pcnt] <= word;
              pcnt <= pcnt + 2'd1;
            end
          end
          xxh64_pkg::S_RND_MUL: t <= acc;
          xxh64_pkg::S_RND_ROT: begin
            t <= xxh64_pkg::rotl(lane[li] + t, 6'd31);
          end
          xxh64_pkg::S_RND_MUL2: begin
            lane[li] <= acc;
            li <= li + 2'd1;
          end
          xxh64_pkg::S_FIN_ROT: begin
            h <= xxh64_pkg::rotl(lane[0], 6'd1) + xxh64_pkg::rotl(lane[1], 6'd7) +
                 xxh64_pkg::rotl(lane[2], 6'd12) + xxh64_pkg::rotl(lane[3], 6'd18);
            li <= '0;
          end
          xxh64_pkg::S_FIN_MRG_MUL:  t <= acc;
          xxh64_pkg::S_FIN_MRG_ROT:  t <= xxh64_pkg::rotl(t, 6'd31);
          xxh64_pkg::S_FIN_MRG_MUL2: h <= h ^ acc;
          xxh64_pkg::S_FIN_MRG_MUL3: begin
            h <= acc + xxh64_pkg::P4;
            li <= li + 2'd1;
          end
          xxh64_pkg::S_FIN_LEN: begin
            h <= ((total >= LENGTH_BITS'(32)) ? h : mseed + xxh64_pkg::P5) + 64'(total);
          end
          xxh64_pkg::S_T8_MUL:  t <= acc;
          xxh64_pkg::S_T8_ROT:  t <= xxh64_pkg::rotl(t, 6'd31);
          xxh64_pkg::S_T8_MUL2: h <= xxh64_pkg::rotl(h ^ acc, 6'd27);
          xxh64_pkg::S_T8_MUL3: begin
            h <= acc + xxh64_pkg::P4;
            if (ti != pcnt) begin
              ti <= ti + 2'd1;
            end else begin
              nb <= '0;
            end
          end
          xxh64_pkg::S_T4_MUL: begin
            h <= xxh64_pkg::rotl(h ^ acc, 6'd23);
            word <= word >> 32;
            nb <= nb - 4'd4;
          end
          xxh64_pkg::S_T4_MUL2: h <= acc + xxh64_pkg::P3;
          xxh64_pkg::S_T1_MUL: begin
            h <= xxh64_pkg::rotl(h ^ acc, 6'd11);
            word <= word >> 8;
            nb <= nb - 4'd1;
          end
          xxh64_pkg::S_T1_MUL2: h <= acc;
          xxh64_pkg::S_AV1: h <= acc;
          xxh64_pkg::S_AV2: h <= h ^ (h >> 29);
          xxh64_pkg::S_AV3: h <= acc;
          xxh64_pkg::S_AV4: h <= h ^ (h >> 32);
          xxh64_pkg::S_OUT: begin
            if (!hv_valid || out_ready) begin
              hv <= h;
              hv_valid <= 1'b1;
              pcnt <= '0;
              total <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[sv/xxhash64_stream.sv]
// xxhash64_stream: top level of the streaming XXH64 hash engine.
// Depends on xxh64_pkg, xxh64_front, xxh64_fifo, xxh64_back.
//
//  channel  | dir | contents
//  s_axis   | in  | tdata: data_word[63:0], byte_count[67:64]; tlast: last_word
//  m_axis   | out | tdata: hash_value[63:0]
//  cfg      | in  | seed, written when cfg_we is high
//
// Every 64-bit multiply is built from 32x32 partial products on one shared multiplier.
// A full word is buffered, or, when it closes a stripe, runs four lane rounds of two
// multiplies and a rotate step; the last word adds merge, tail folds and avalanche.
// Reset is synchronous; no clearing pass. A stalled output holds the back end
// in its output step while the front keeps filling the two-entry queue.
module xxhash64_stream #(
  parameter int LENGTH_BITS = xxh64_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // data_word[63:0], byte_count[67:64], zero fill
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // hash_value[63:0]
);

  logic [63:0] seed;
  logic push, full, pop, empty;
  xxh64_pkg::fe_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  xxh64_front u_front (
    .clk(clk), .rst(rst), .seed(seed),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_word(s_axis_tdata[63:0]), .in_count(s_axis_tdata[67:64]),
    .in_last(s_axis_tlast),
    .push(push), .push_item(push_item), .full(full)
  );

  xxh64_fifo #(.DEPTH(xxh64_pkg::FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(full),
    .pop(pop), .pop_item(pop_item), .empty(empty)
  );

  xxh64_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk(clk), .rst(rst), .empty(empty), .item(pop_item), .pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_hash(m_axis_tdata)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !s_axis_tready) else $error("push while queue full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("hash changed while stalled");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for xxhash64_stream (streaming XXH64).
// Drives word-packed messages with random gaps and output stalls and checks each
// hash against an in-bench XXH64 model. Depends on xxh64_pkg and the RTL.
module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  xxhash64_stream DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [63:0] seed_reg = '0, msg_seed, lanes [4], stripe_buf [3], byte_total;
  int unsigned buf_cnt = 0;
  bit          in_msg = 0;
  logic [63:0] hash_q [$];
  int          errors = 0, words_sent = 0, hashes_seen = 0;
  int unsigned send_idle = 0, recv_stall = 0;

  function automatic logic [63:0] rl(logic [63:0] x, int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] lane_rnd(logic [63:0] a, logic [63:0] w);
    a = a + w * xxh64_pkg::P2;
    return rl(a, 31) * xxh64_pkg::P1;
  endfunction

  function automatic logic [63:0] fold8(logic [63:0] h, logic [63:0] w);
    h = h ^ lane_rnd(64'd0, w);
    return rl(h, 27) * xxh64_pkg::P1 + xxh64_pkg::P4;
  endfunction

  function automatic void absorb(logic [63:0] w);
    if (buf_cnt == 3) begin
      lanes[0] = lane_rnd(lanes[0], stripe_buf[0]);
      lanes[1] = lane_rnd(lanes[1], stripe_buf[1]);
      lanes[2] = lane_rnd(lanes[2], stripe_buf[2]);
      lanes[3] = lane_rnd(lanes[3], w);
      buf_cnt = 0;
    end else begin
      stripe_buf[buf_cnt] = w;
      buf_cnt++;
    end
  endfunction

  function automatic logic [63:0] digest(logic [63:0] w, int unsigned n);
    logic [63:0] h;
    if (byte_total >= 32) begin
      h = rl(lanes[0], 1) + rl(lanes[1], 7) + rl(lanes[2], 12) + rl(lanes[3], 18);
      for (int i = 0; i < 4; i++)
        h = (h ^ lane_rnd(64'd0, lanes[i])) * xxh64_pkg::P1 + xxh64_pkg::P4;
    end else h = msg_seed + xxh64_pkg::P5;
    h = h + byte_total;
    for (int i = 0; i < buf_cnt; i++) h = fold8(h, stripe_buf[i]);
    if (n == 8) h = fold8(h, w);
    else begin
      if (n >= 4) begin
        h = h ^ (xxh64_pkg::P1 * {32'd0, w[31:0]});
        h = rl(h, 23) * xxh64_pkg::P2 + xxh64_pkg::P3;
        w = w >> 32;
        n -= 4;
      end
      for (int i = 0; i < n; i++) begin
        h = h ^ (xxh64_pkg::P5 * {56'd0, w[7:0]});
        h = rl(h, 11) * xxh64_pkg::P1;
        w = w >> 8;
      end
    end
    h = h ^ (h >> 33); h = h * xxh64_pkg::P2;
    h = h ^ (h >> 29); h = h * xxh64_pkg::P3;
    return h ^ (h >> 32);
  endfunction

  function automatic void predict_word(logic [63:0] w, logic [3:0] bc, bit lst);
    int unsigned n;
    if (!in_msg) begin
      msg_seed = seed_reg;
      lanes[0] = seed_reg + xxh64_pkg::P1 + xxh64_pkg::P2;
      lanes[1] = seed_reg + xxh64_pkg::P2;
      lanes[2] = seed_reg; lanes[3] = seed_reg - xxh64_pkg::P1;
      buf_cnt = 0; byte_total = 0; in_msg = 1;
    end
    if (!lst) begin
      byte_total += 8;
      absorb(w);
      return;
    end
    n = (bc > 8) ? 8 : bc;
    if (n < 8) w = w & ~(~64'd0 << (8 * n));
    byte_total += n;
    if (n == 8 && buf_cnt == 3) begin
      absorb(w);
      hash_q.push_back(digest(64'd0, 0));
    end else hash_q.push_back(digest(w, n));
    buf_cnt = 0; in_msg = 0;
  endfunction

  task automatic send_word(logic [63:0] w, logic [3:0] bc, bit lst);
    int gap;
    gap = 0;
    while (send_idle != 0 && $urandom_range(99) < send_idle) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, bc, w};
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_word(w, bc, lst);
    words_sent++;
  endtask

  task automatic send_msg(int nfull, logic [3:0] tail_bc);
    for (int i = 0; i < nfull; i++)
      send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
    send_word({$urandom, $urandom}, tail_bc, 1'b1);
  endtask

  task automatic drain();
    int guard = 0;
    s_axis_tvalid <= 1'b0;
    while (hash_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] s);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= s;
    @(posedge clk);
    seed_reg = s;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      hashes_seen++;
      if (hash_q.size() == 0) begin
        $display("%0t: unexpected hash, expected none, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        logic [63:0] want;
        want = hash_q.pop_front();
        if (want !== m_axis_tdata) begin
          $display("%0t: hash mismatch, expected %h, got %h", $time, want, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_word(64'h0, 4'd0, 1'b1);                     // empty message
    for (int b = 0; b <= 15; b++) send_msg(0, 4'(b)); // every count, incl. saturation
    send_word(~64'd0, 4'd8, 1'b0);                    // short count on non-last word
    send_word(~64'd0, 4'd3, 1'b0);
    send_word(64'h0, 4'd0, 1'b1);
    send_msg(3, 4'd8);                                // full last closes a stripe
    send_msg(4, 4'd7);
    send_msg(7, 4'd8);
  endtask

  task automatic test_seed_mid_message();
    send_word({$urandom, $urandom}, 4'd8, 1'b0);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= 64'h0123_4567_89ab_cdef;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_word({$urandom, $urandom}, 4'd5, 1'b1);
    drain();
    seed_reg = 64'h0123_4567_89ab_cdef;
    send_msg(2, 4'd4);
  endtask

  task automatic test_random(int words);
    int n;
    while (words > 0) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(9);
      send_msg(n, 4'($urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(8)));
      words -= n + 1;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_seed(~64'd0);
    test_directed();
    test_seed_mid_message();
    write_seed(64'd0);
    test_random(250);
    send_idle = 55; write_seed({$urandom, $urandom});
    test_random(250);
    send_idle = 0; recv_stall = 55; write_seed({$urandom, $urandom});
    test_random(250);
    send_idle = 7; recv_stall = 7; write_seed(64'h8000_0000_0000_0001);
    test_random(230);
    drain();
    $display("covered %0d words and %0d hashes over seeds 0, all-ones and random,",
             words_sent, hashes_seen);
    $display("with byte counts 0..15, stripe-closing tails and sender/receiver idling");
    if (errors == 0 && hash_q.size() == 0) $display("xxhash64_stream regression: pass");
    else $display("xxhash64_stream regression: fail");
    $finish;
  end

  initial begin
    #10000000;
    $display("xxhash64_stream regression: fail");
    $finish;
  end
endmodule
